// File: rtl/pgst_pkg.sv
`default_nettype none
package pgst_pkg;

	localparam int TIME_BITS      = 32;
	localparam int EXP_TABLE_SIZE = 256;
	localparam int IDX_BITS       = $clog2(EXP_TABLE_SIZE);
	localparam int FRAC_BITS      = 24;
	localparam int RATE_BITS      = 24;
	localparam int DROP_BITS      = 16;
	localparam int Q16_BITS       = 17;
	localparam int P_BITS         = TIME_BITS + RATE_BITS;
	localparam int SH_LIMIT       = 17;

	localparam logic [DROP_BITS-1:0] DROP_RESET = 16'd66;
	localparam logic [RATE_BITS-1:0] RATE_RESET = 24'd8068;
	localparam logic [Q16_BITS-1:0]  ONE_Q16    = 17'd65536;

	typedef logic [TIME_BITS-1:0] time_t;
	typedef logic [Q16_BITS-1:0]  q16_t;

	typedef enum logic {
		REG_DROP = 1'b0,
		REG_RATE = 1'b1
	} reg_idx_t;

	typedef enum logic {
		CMD_PULSE = 1'b0,
		CMD_QUERY = 1'b1
	} item_cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXPO,
		ST_FACTOR,
		ST_DECAY,
		ST_COMMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic expo;
		logic factor;
		logic decay;
		logic commit;
	} dp_cmd_t;

	typedef struct packed {
		logic out_busy;
		logic seen;
	} dp_status_t;

	// 2^-(2^-k) in Q0.32, k = 1..10
	localparam logic [31:0] HALF_POW [10] = '{
		32'd3037000500, 32'd3611622603, 32'd3938502376, 32'd4112874773,
		32'd4202935003, 32'd4248701965, 32'd4271771997, 32'd4283353945,
		32'd4289156690, 32'd4292061010
	};

	typedef q16_t exp_table_t [EXP_TABLE_SIZE];

	// 2^-(i / EXP_TABLE_SIZE) in Q1.16, built at elaboration
	function automatic exp_table_t build_exp_table();
		exp_table_t  tab;
		logic [63:0] v;
		logic [63:0] r;
		for (int i = 0; i < EXP_TABLE_SIZE; i++) begin
			v = 64'h1_0000_0000;
			for (int j = 0; j < IDX_BITS; j++) begin
				if (((i >> (IDX_BITS - 1 - j)) & 1) != 0)
					v = (v * {32'd0, HALF_POW[j]} + 64'h8000_0000) >> 32;
			end
			r = (v + 64'd32768) >> 16;
			tab[i] = r[Q16_BITS-1:0];
		end
		return tab;
	endfunction

	localparam exp_table_t EXP_TABLE = build_exp_table();

endpackage
`default_nettype wire

// File: rtl/pulse_gain_sag_tracker.sv
`default_nettype none
// A result is registered in the output register after the four-step sequence of the
// controller (exponent multiply, table lookup and shift, deficit multiply, pulse update
// multiply); no input is taken meanwhile. The last step waits while out_busy is set.
// A new input is taken while the previous result still waits in the output register.
// Reset (arst_n, asynchronous, active low) clears deficit, last pulse time and the
// pulse flag and restores the register defaults; no clearing pass is needed.
module pulse_gain_sag_tracker (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_we,
	input  wire         cfg_index,
	input  wire  [23:0] cfg_wdata,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [31:0] s_tdata,  // [31:0] event_time
	input  wire         s_tuser,  // [0] cmd
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [23:0] m_tdata,  // [16:0] gain, [23:17] zero
	output logic        m_tuser   // [0] order_error
);
	import pgst_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;
	logic [16:0] gain;

	pgst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	pgst_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_cmd    (s_tuser),
		.in_time   (s_tdata),
		.cmd       (cmd),
		.status    (status),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.out_gain  (gain),
		.out_err   (m_tuser)
	);

	assign m_tdata = {7'd0, gain};

`ifndef NO_ASSERTIONS
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input taken while an item is in progress");

	a_err_needs_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> status.seen)
		else $error("order error flagged before any pulse");

	a_gain_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[16:0] <= 17'd65536))
		else $error("gain above one");

	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !(m_tvalid && !m_tready))
		else $error("result overwritten before transfer");
`endif

endmodule
`default_nettype wire

// File: rtl/pgst_ctrl.sv
`default_nettype none
module pgst_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  s_tvalid,
	output logic                 s_tready,
	input  pgst_pkg::dp_status_t status,
	output pgst_pkg::dp_cmd_t    cmd
);
	import pgst_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_EXPO;
				end
			end
			ST_EXPO: begin
				cmd.expo = 1'b1;
				state_d  = ST_FACTOR;
			end
			ST_FACTOR: begin
				cmd.factor = 1'b1;
				state_d    = ST_DECAY;
			end
			ST_DECAY: begin
				cmd.decay = 1'b1;
				state_d   = ST_COMMIT;
			end
			ST_COMMIT: begin
				// hold until the previous result has been taken
				if (!status.out_busy) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule
`default_nettype wire

// File: rtl/pgst_dp.sv
`default_nettype none
module pgst_dp (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   cfg_we,
	input  wire                   cfg_index,
	input  wire  [23:0]           cfg_wdata,
	input  wire                   in_cmd,
	input  wire  [31:0]           in_time,
	input  pgst_pkg::dp_cmd_t     cmd,
	output pgst_pkg::dp_status_t  status,
	input  wire                   m_tready,
	output logic                  m_tvalid,
	output logic [16:0]           out_gain,
	output logic                  out_err
);
	import pgst_pkg::*;

	logic [DROP_BITS-1:0] drop_q;
	logic [RATE_BITS-1:0] rate_q;
	q16_t                 deficit_q;
	time_t                last_q;
	logic                 seen_q;

	logic                 cmd_q;
	time_t                t_q;
	logic                 err_q;
	logic [P_BITS-1:0]    p_q;
	logic                 one_q;
	logic                 zero_q;
	q16_t                 e_q;
	q16_t                 d_q;
	logic                 valid_q;
	q16_t                 gain_q;
	logic                 oerr_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drop_q <= DROP_RESET;
			rate_q <= RATE_RESET;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_DROP: drop_q <= cfg_wdata[DROP_BITS-1:0];
				REG_RATE: rate_q <= cfg_wdata[RATE_BITS-1:0];
				default: ;
			endcase
		end
	end

	// exponent stage
	logic  err_c;
	time_t dt_c;
	always_comb begin
		err_c = seen_q && (t_q < last_q);
		dt_c  = (seen_q && !err_c) ? (t_q - last_q) : '0;
	end

	// factor stage
	logic [TIME_BITS-1:0] sh_c;
	logic [IDX_BITS-1:0]  idx_c;
	q16_t                 e_c;
	always_comb begin
		sh_c  = p_q[P_BITS-1:FRAC_BITS];
		idx_c = p_q[FRAC_BITS-1 -: IDX_BITS];
		if (one_q)
			e_c = ONE_Q16;
		else if (zero_q || sh_c >= TIME_BITS'(SH_LIMIT))
			e_c = '0;
		else
			e_c = EXP_TABLE[idx_c] >> sh_c[4:0];
	end

	// decay stage
	logic [2*Q16_BITS:0] prod_c;
	q16_t                d_c;
	always_comb begin
		prod_c = (35'(deficit_q) * 35'(e_q)) + 35'd32768;
		if (prod_c[2*Q16_BITS:16] > {{(2*Q16_BITS-15-Q16_BITS){1'b0}}, ONE_Q16})
			d_c = ONE_Q16;
		else
			d_c = prod_c[16 +: Q16_BITS];
	end

	// pulse update
	q16_t                inv_c;
	logic [2*Q16_BITS:0] upd_c;
	logic [19:0]         nd_c;
	q16_t                ndsat_c;
	always_comb begin
		inv_c   = ONE_Q16 - {1'b0, drop_q};
		upd_c   = (35'(d_q) * 35'(inv_c)) + 35'd32768;
		nd_c    = {1'b0, upd_c[2*Q16_BITS:16]} + 20'(drop_q);
		ndsat_c = (nd_c > 20'(ONE_Q16)) ? ONE_Q16 : nd_c[Q16_BITS-1:0];
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= in_cmd;
			t_q   <= time_t'(in_time);
		end
		if (cmd.expo) begin
			err_q  <= err_c;
			p_q    <= P_BITS'(dt_c) * P_BITS'(rate_q);
			one_q  <= (rate_q == '0) || (dt_c == '0);
			zero_q <= 64'(dt_c) >= 64'h100_0000_0000;
		end
		if (cmd.factor)
			e_q <= e_c;
		if (cmd.decay)
			d_q <= d_c;
		if (cmd.commit) begin
			gain_q <= ONE_Q16 - d_q;
			oerr_q <= err_q;
		end
	end

	// tracker state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deficit_q <= '0;
			last_q    <= '0;
			seen_q    <= 1'b0;
		end else if (cmd.commit && (cmd_q == CMD_PULSE)) begin
			deficit_q <= ndsat_c;
			seen_q    <= 1'b1;
			if (!err_q)
				last_q <= t_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (cmd.commit)
			valid_q <= 1'b1;
		else if (m_tready)
			valid_q <= 1'b0;
	end

	assign m_tvalid        = valid_q;
	assign out_gain        = gain_q;
	assign out_err         = oerr_q;
	assign status.out_busy = valid_q && !m_tready;
	assign status.seen     = seen_q;

endmodule
`default_nettype wire
